/* hw/rtl/cqsd_pkg.sv */
// Shared types and codes for the circular queue with sorted dump.
`timescale 1ns / 1ps

package cqsd_pkg;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP        = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DUMP_SORTED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } res_item_t;

endpackage

/* hw/rtl/cqsd_mem.sv */
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps

module cqsd_mem
    import cqsd_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IW    = $clog2(DEPTH)
)
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [IW-1:0]             waddr,
    input  logic signed [VALUE_W-1:0] wdata,
    input  logic                      re,
    input  logic [IW-1:0]             raddr,
    output logic signed [VALUE_W-1:0] rdata
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/cqsd_cmp.sv */
// Shared compare unit: decides whether a read entry becomes the new pass winner.
`timescale 1ns / 1ps

module cqsd_cmp
    import cqsd_pkg::*;
#(
    parameter int IW = 3
)
(
    input  logic                      sorted,
    input  logic signed [VALUE_W-1:0] cand_val,
    input  logic [IW-1:0]             cand_pos,
    input  logic                      prev_vld,
    input  logic signed [VALUE_W-1:0] prev_val,
    input  logic [IW-1:0]             prev_pos,
    input  logic                      best_vld,
    input  logic signed [VALUE_W-1:0] best_val,
    input  logic [IW-1:0]             best_pos,
    output logic                      take
);

    // Keys order by signed value first and queue position second, which keeps
    // equal values in queue order and makes every key distinct.
    localparam int KW = VALUE_W + IW;

    logic [KW-1:0] cand_key;
    logic [KW-1:0] prev_key;
    logic [KW-1:0] best_key;
    logic          above_prev;
    logic          below_best;

    assign cand_key = {~cand_val[VALUE_W-1], cand_val[VALUE_W-2:0], cand_pos};
    assign prev_key = {~prev_val[VALUE_W-1], prev_val[VALUE_W-2:0], prev_pos};
    assign best_key = {~best_val[VALUE_W-1], best_val[VALUE_W-2:0], best_pos};

    assign above_prev = !prev_vld || (prev_key < cand_key);
    assign below_best = !best_vld || (cand_key < best_key);

    assign take = !sorted || (above_prev && below_best);

endmodule

/* hw/rtl/circular_queue_sorted_dump_unit.sv */
// Top level: ring-buffer queue with in-order and sorted dump sequencer.
`timescale 1ns / 1ps

//  channel  signals                 direction  item
//  cmd      cmd_valid/cmd_ready/cmd  in         command and value
//  res      res_valid/res_ready/res  out        data, status and last flag
//
// Insert, delete and a dump of an empty queue finish in the execute state,
// waiting there for the result register. An in-order dump takes each entry
// through the scan, settle and emit states. A sorted dump makes one pass over
// all n entries per result through the single compare unit and memory read port.
// Reset clears the indices and the count; entries need no clearing.
// A stalled result holds the sequencer; a command is taken only when idle.

module circular_queue_sorted_dump_unit
    import cqsd_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_ready,
    output res_item_t res
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 2;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SETTLE = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [IW-1:0]             front_reg, front_next;
    logic [IW-1:0]             rear_reg, rear_next;
    logic [CW-1:0]             occ_reg, occ_next;
    logic [IW-1:0]             out_cnt_reg, out_cnt_next;
    logic [IW-1:0]             issue_pos_reg, issue_pos_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [IW-1:0]             rd_pos_reg, rd_pos_next;
    logic                      best_vld_reg, best_vld_next;
    logic signed [VALUE_W-1:0] best_val_reg, best_val_next;
    logic [IW-1:0]             best_pos_reg, best_pos_next;
    logic signed [VALUE_W-1:0] prev_val_reg, prev_val_next;
    logic [IW-1:0]             prev_pos_reg, prev_pos_next;
    logic                      res_valid_reg, res_valid_next;
    res_item_t                 res_reg, res_next;

    logic                      slot_free;
    logic                      sorted;
    logic                      is_full;
    logic                      is_empty;
    logic [IW-1:0]             last_pos;
    logic                      final_out;
    logic [IW:0]               addr_sum;
    logic [IW-1:0]             rd_addr;
    logic                      mem_we;
    logic                      mem_re;
    logic signed [VALUE_W-1:0] rd_data;
    logic                      take;

    assign slot_free = !res_valid_reg || res_ready;
    assign sorted    = (cmd_reg == CMD_DUMP_SORTED);
    assign is_full   = (occ_reg == CW'(DEPTH));
    assign is_empty  = (occ_reg == '0);
    assign last_pos  = IW'(occ_reg - CW'(1));
    assign final_out = (out_cnt_reg == last_pos);

    assign addr_sum = {1'b0, front_reg} + {1'b0, issue_pos_reg};
    assign rd_addr  = (addr_sum >= (IW+1)'(DEPTH)) ? IW'(addr_sum - (IW+1)'(DEPTH))
                                                    : addr_sum[IW-1:0];

    function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    cqsd_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (rear_reg),
        .wdata (val_reg),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    cqsd_cmp #(
        .IW (IW)
    ) u_cmp (
        .sorted   (sorted),
        .cand_val (rd_data),
        .cand_pos (rd_pos_reg),
        .prev_vld (out_cnt_reg != '0),
        .prev_val (prev_val_reg),
        .prev_pos (prev_pos_reg),
        .best_vld (best_vld_reg),
        .best_val (best_val_reg),
        .best_pos (best_pos_reg),
        .take     (take)
    );

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        occ_next       = occ_reg;
        out_cnt_next   = out_cnt_reg;
        issue_pos_next = issue_pos_reg;
        rd_vld_next    = 1'b0;
        rd_pos_next    = issue_pos_reg;
        best_vld_next  = best_vld_reg;
        best_val_next  = best_val_reg;
        best_pos_next  = best_pos_reg;
        prev_val_next  = prev_val_reg;
        prev_pos_next  = prev_pos_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        cmd_ready      = 1'b0;

        // Each read result is judged in the cycle after its address was issued.
        if (rd_vld_reg && take)
        begin
            best_vld_next = 1'b1;
            best_val_next = rd_data;
            best_pos_next = rd_pos_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next   = cmd.command;
                    val_next   = cmd.value;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (cmd_reg == CMD_INSERT)
                begin
                    if (slot_free)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{data: '0, status: is_full ? ST_FULL : ST_OK,
                                           last: 1'b1};
                        if (!is_full)
                        begin
                            mem_we    = 1'b1;
                            rear_next = wrap_next(rear_reg);
                            occ_next  = occ_reg + CW'(1);
                        end
                        state_next = S_IDLE;
                    end
                end
                else if (cmd_reg == CMD_DELETE || is_empty)
                begin
                    if (slot_free)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{data: '0, status: is_empty ? ST_EMPTY : ST_OK,
                                           last: 1'b1};
                        if (!is_empty)
                        begin
                            front_next = wrap_next(front_reg);
                            occ_next   = occ_reg - CW'(1);
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    out_cnt_next   = '0;
                    issue_pos_next = '0;
                    best_vld_next  = 1'b0;
                    state_next     = S_SCAN;
                end
            end

            S_SCAN:
            begin
                mem_re      = 1'b1;
                rd_vld_next = 1'b1;
                // An in-order pass reads one entry; a sorted pass reads them all.
                if (!sorted || issue_pos_reg == last_pos)
                begin
                    state_next = S_SETTLE;
                end
                else
                begin
                    issue_pos_next = issue_pos_reg + IW'(1);
                end
            end

            S_SETTLE:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{data: best_val_reg, status: ST_OK, last: final_out};
                    prev_val_next  = best_val_reg;
                    prev_pos_next  = best_pos_reg;
                    if (final_out)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_cnt_next   = out_cnt_reg + IW'(1);
                        issue_pos_next = sorted ? '0 : out_cnt_reg + IW'(1);
                        best_vld_next  = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            rear_reg      <= '0;
            occ_reg       <= '0;
            out_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            best_vld_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            occ_reg       <= occ_next;
            out_cnt_reg   <= out_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            best_vld_reg  <= best_vld_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        issue_pos_reg <= issue_pos_next;
        rd_pos_reg    <= rd_pos_next;
        best_val_reg  <= best_val_next;
        best_pos_reg  <= best_pos_next;
        prev_val_reg  <= prev_val_next;
        prev_pos_reg  <= prev_pos_next;
        res_reg       <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Where the rear index must sit given the front index and the count.
    logic [SW-1:0] rear_sum;
    logic [IW-1:0] rear_expect;

    assign rear_sum    = SW'(front_reg) + SW'(occ_reg);
    assign rear_expect = (rear_sum >= SW'(DEPTH)) ? IW'(rear_sum - SW'(DEPTH))
                                                   : rear_sum[IW-1:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        rear_reg == rear_expect)
        else $error("rear index does not match front index plus count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !rd_vld_reg)
        else $error("memory read still in flight while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != ST_OK) |-> (res_reg.last && res_reg.data == '0))
        else $error("status-only result is not a single final item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> best_vld_reg)
        else $error("pass ended without a selected entry");

endmodule
